>>> hdl/rsfs_pkg.sv
// rsfs_pkg: shared types and constants for the ranked sensor failover selector
// used by rsfs_ctrl, rsfs_dp and the top level; no dependencies
package rsfs_pkg;

	localparam int MAX_SENSORS_DEF = 16;
	localparam int MAX_RANK_DEF    = 32;

	localparam int SIDX_W     = 4;
	localparam int SCORE_W    = 6;
	localparam int USE_W      = 5;
	localparam int RANK_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [USE_W-1:0]  SENSORS_RST = 5'd16;
	localparam logic [RANK_W-1:0] RANK_RST    = 6'd8;

	localparam logic [CFG_IDX_W-1:0] REG_SENSORS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_SIZE      = 2'd1;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	typedef struct packed {
		logic capture;
		logic scan_step;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_status_t;

endpackage

>>> hdl/rsfs_ctrl.sv
// rsfs_ctrl: sequencer for the failover selector (idle, scan, update)
// drives rsfs_dp through dp_cmd_t and owns the output valid flag; uses rsfs_pkg
module rsfs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rsfs_pkg::dp_cmd_t      cmd,
	input  rsfs_pkg::dp_status_t   status
);
	import rsfs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = (kind == KIND_REPORT) ? ST_UPDATE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					cmd.update = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/rsfs_dp.sv
// rsfs_dp: per-sensor history, success counts, tried marks, ranking scan and result word
// config registers live here; commanded by rsfs_ctrl; uses rsfs_pkg
module rsfs_dp #(
	parameter int MAX_SENSORS = rsfs_pkg::MAX_SENSORS_DEF,
	parameter int MAX_RANK    = rsfs_pkg::MAX_RANK_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [rsfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsfs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               kind,
	input  logic [rsfs_pkg::SIDX_W-1:0]        sensor_index,
	input  logic                               outcome_ok,
	input  rsfs_pkg::dp_cmd_t                  cmd,
	output rsfs_pkg::dp_status_t               status,
	output logic                               found,
	output logic [rsfs_pkg::SIDX_W-1:0]        chosen_sensor,
	output logic [rsfs_pkg::SCORE_W-1:0]       score
);
	import rsfs_pkg::*;

	localparam int IW = $clog2(MAX_SENSORS);
	localparam int NW = $clog2(MAX_SENSORS + 1);
	localparam int LW = $clog2(MAX_RANK + 1);
	localparam int PW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int CW = (NW > SIDX_W) ? NW : SIDX_W;

	logic [USE_W-1:0]  sensors_q;
	logic [RANK_W-1:0] rank_q;

	logic              kind_q;
	logic [SIDX_W-1:0] idx_q;
	logic              ok_q;
	logic [IW-1:0]     scan_q;
	logic              have_q;
	logic [IW-1:0]     best_q;
	logic [LW-1:0]     bestc_q;

	logic [MAX_RANK-1:0] bits_q  [MAX_SENSORS];
	logic [LW-1:0]       fill_q  [MAX_SENSORS];
	logic [PW-1:0]       pos_q   [MAX_SENSORS];
	logic [LW-1:0]       tally_q [MAX_SENSORS];
	logic [MAX_SENSORS-1:0] tried_q;

	logic [NW-1:0]       grp_n;
	logic [LW-1:0]       hist_len;
	logic [IW-1:0]       idx_sel;
	logic [IW-1:0]       rd_idx;
	logic [MAX_RANK-1:0] rd_bits;
	logic [LW-1:0]       rd_fill;
	logic [PW-1:0]       rd_pos;
	logic [LW-1:0]       rd_tally;
	logic                rd_tried;
	logic                take;
	logic                rep_in;
	logic                rep_lt_max;
	logic [PW-1:0]       pos_cur;
	logic [LW-1:0]       pos_inc;
	logic [PW-1:0]       pos_next;
	logic                full;
	logic [LW-1:0]       fill_next;
	logic [LW-1:0]       tally_new;
	logic [MAX_SENSORS-1:0] grp_mask;

	always_comb begin
		if (32'(sensors_q) > MAX_SENSORS) begin
			grp_n = NW'(MAX_SENSORS);
		end else begin
			grp_n = NW'(sensors_q);
		end
		if (rank_q == '0) begin
			hist_len = LW'(1);
		end else if (32'(rank_q) > MAX_RANK) begin
			hist_len = LW'(MAX_RANK);
		end else begin
			hist_len = LW'(rank_q);
		end
		for (int i = 0; i < MAX_SENSORS; i++) begin
			grp_mask[i] = (i < int'(grp_n));
		end
	end

	assign idx_sel  = IW'(idx_q);
	assign rd_idx   = (kind_q == KIND_REPORT) ? idx_sel : scan_q;
	assign rd_bits  = bits_q[rd_idx];
	assign rd_fill  = fill_q[rd_idx];
	assign rd_pos   = pos_q[rd_idx];
	assign rd_tally = tally_q[rd_idx];
	assign rd_tried = tried_q[rd_idx];

	// scan one sensor a cycle, strict compare keeps the lowest index on ties
	assign take = (NW'(scan_q) < grp_n) && !rd_tried && (!have_q || (rd_tally > bestc_q));
	assign status.scan_last = ({1'b0, NW'(scan_q)} + (NW + 1)'(1)) >= {1'b0, grp_n};

	assign rep_in     = CW'(idx_q) < CW'(grp_n);
	assign rep_lt_max = 32'(idx_q) < MAX_SENSORS;

	// running count: drop the overwritten bit once the history is full
	assign pos_cur   = (LW'(rd_pos) >= hist_len) ? '0 : rd_pos;
	assign pos_inc   = LW'(pos_cur) + LW'(1);
	assign pos_next  = (pos_inc >= hist_len) ? '0 : PW'(pos_inc);
	assign full      = rd_fill >= hist_len;
	assign fill_next = full ? hist_len : rd_fill + LW'(1);
	assign tally_new = rd_tally - LW'(full & rd_bits[pos_cur]) + LW'(ok_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensors_q <= SENSORS_RST;
			rank_q    <= RANK_RST;
			kind_q    <= KIND_REQUEST;
			idx_q     <= '0;
			ok_q      <= 1'b0;
			scan_q    <= '0;
			have_q    <= 1'b0;
			best_q    <= '0;
			bestc_q   <= '0;
			tried_q   <= '0;
			for (int i = 0; i < MAX_SENSORS; i++) begin
				fill_q[i]  <= '0;
				pos_q[i]   <= '0;
				tally_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SENSORS_IN_USE: begin
						sensors_q <= cfg_data[USE_W-1:0];
					end
					REG_RANK_SIZE: begin
						rank_q <= cfg_data[RANK_W-1:0];
						for (int i = 0; i < MAX_SENSORS; i++) begin
							fill_q[i]  <= '0;
							pos_q[i]   <= '0;
							tally_q[i] <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.capture) begin
				kind_q  <= kind;
				idx_q   <= sensor_index;
				ok_q    <= outcome_ok;
				scan_q  <= '0;
				have_q  <= 1'b0;
				best_q  <= '0;
				bestc_q <= '0;
			end
			if (cmd.scan_step) begin
				if (take) begin
					have_q  <= 1'b1;
					best_q  <= scan_q;
					bestc_q <= rd_tally;
				end
				scan_q <= scan_q + IW'(1);
			end
			if (cmd.update) begin
				if (kind_q == KIND_REQUEST) begin
					if (have_q) begin
						tried_q[best_q] <= 1'b1;
					end else begin
						tried_q <= tried_q & ~grp_mask;
					end
				end else if (rep_in) begin
					fill_q[idx_sel]  <= fill_next;
					pos_q[idx_sel]   <= pos_next;
					tally_q[idx_sel] <= tally_new;
					if (ok_q) begin
						tried_q <= tried_q & ~grp_mask;
					end
				end
			end
		end
	end

	// history bits and result word need no reset
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (kind_q == KIND_REQUEST) begin
				found         <= have_q;
				chosen_sensor <= have_q ? SIDX_W'(best_q) : '0;
				score         <= have_q ? SCORE_W'(bestc_q) : '0;
			end else begin
				found         <= 1'b1;
				chosen_sensor <= idx_q;
				if (rep_in) begin
					bits_q[idx_sel][pos_cur] <= ok_q;
					score <= SCORE_W'(tally_new);
				end else if (rep_lt_max) begin
					score <= SCORE_W'(rd_tally);
				end else begin
					score <= '0;
				end
			end
		end
	end

endmodule

>>> hdl/ranked_sensor_failover_selector.sv
// ranked_sensor_failover_selector: top level of the sensor failover selector
// joins rsfs_ctrl and rsfs_dp; uses rsfs_pkg
//
// Usage:
//  in channel (in_valid/in_ready): kind 0 asks for the next candidate sensor,
//  kind 1 reports a read outcome (sensor_index, outcome_ok) for one sensor.
//  out channel (out_valid/out_ready): exactly one word per input word,
//  found, chosen_sensor and score (success count within the recent history).
//  cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//  sensors_in_use, index 1 is rank_size; writing rank_size empties all
//  histories. cfg_ready is always high; write only while the block is idle.
//  Timing: a request scans one sensor a cycle over the active group (a
//  single scan step if it is empty), then an update step loads the result,
//  waiting there until the output register is free; a report goes straight
//  to the update step. in_ready returns the cycle after the result loads.
//  One word is in flight at a time; in_ready is high only when idle.
//  If the receiver stalls, a finished word waits in the output register,
//  the next input word is still taken, and its result waits in the update
//  step until the output register frees up.
//  Reset: all histories empty, counts zero, no sensor tried, 16 sensors,
//  rank size 8.
module ranked_sensor_failover_selector #(
	parameter int MAX_SENSORS = rsfs_pkg::MAX_SENSORS_DEF,
	parameter int MAX_RANK    = rsfs_pkg::MAX_RANK_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic [rsfs_pkg::SIDX_W-1:0]        sensor_index,
	input  logic                               outcome_ok,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [rsfs_pkg::SIDX_W-1:0]        chosen_sensor,
	output logic [rsfs_pkg::SCORE_W-1:0]       score,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rsfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsfs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rsfs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	rsfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	rsfs_dp #(
		.MAX_SENSORS (MAX_SENSORS),
		.MAX_RANK    (MAX_RANK)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.sensor_index  (sensor_index),
		.outcome_ok    (outcome_ok),
		.cmd           (cmd),
		.status        (status),
		.found         (found),
		.chosen_sensor (chosen_sensor),
		.score         (score)
	);

endmodule

>>> hdl/rsfs_checker.sv
// rsfs_checker: port-level assertions for ranked_sensor_failover_selector
// bound to the top level below; uses rsfs_pkg for widths
module rsfs_checker #(
	parameter int MAX_RANK = rsfs_pkg::MAX_RANK_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           found,
	input logic [rsfs_pkg::SIDX_W-1:0]    chosen_sensor,
	input logic [rsfs_pkg::SCORE_W-1:0]   score
);
	import rsfs_pkg::*;

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found)
			&& $stable(chosen_sensor) && $stable(score))
	else $error("stalled output word changed");

	// none found comes back all zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> chosen_sensor == '0 && score == '0)
	else $error("none-found word not zero");

	// a count never exceeds the history length
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(score) <= MAX_RANK)
	else $error("score above history length");

	// one word in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input taken while busy");

endmodule

bind ranked_sensor_failover_selector rsfs_checker #(
	.MAX_RANK (MAX_RANK)
) u_rsfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.found         (found),
	.chosen_sensor (chosen_sensor),
	.score         (score)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for ranked_sensor_failover_selector, directed words then
// random failover sequences over several register settings; needs rsfs_pkg and the rtl only
module testbench;
	import rsfs_pkg::*;

	localparam int NSENS = MAX_SENSORS_DEF;
	localparam int NRANK = MAX_RANK_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 185;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int STALL_NONE = 0;
	localparam int STALL_RANDOM = 1;
	localparam int STALL_PATTERN = 2;

	typedef struct packed {
		logic found;
		logic [SIDX_W-1:0] sensor;
		logic [SCORE_W-1:0] score;
	} pick_t;

	class failover_board;
		pick_t picks_due[$];
		logic [NRANK-1:0] hist [NSENS];
		int fill [NSENS];
		int wpos [NSENS];
		int tally [NSENS];
		bit tried [NSENS];
		int group_cfg;
		int rank_cfg;
		int last_pick;
		int errors;
		int checked;

		function new();
			group_cfg = SENSORS_RST;
			rank_cfg = RANK_RST;
			last_pick = -1;
			errors = 0;
			checked = 0;
			clear_histories();
			foreach (tried[i]) tried[i] = 1'b0;
		endfunction

		function int group_len();
			return (group_cfg > NSENS) ? NSENS : group_cfg;
		endfunction

		function int hist_len();
			if (rank_cfg == 0) return 1;
			return (rank_cfg > NRANK) ? NRANK : rank_cfg;
		endfunction

		function void clear_histories();
			foreach (hist[i]) begin
				hist[i] = '0;
				fill[i] = 0;
				wpos[i] = 0;
				tally[i] = 0;
			end
		endfunction

		// only marks inside the current group are cleared
		function void clear_tried();
			for (int i = 0; i < group_len(); i++) tried[i] = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_SENSORS_IN_USE) begin
				group_cfg = data[USE_W-1:0];
			end else if (idx == REG_RANK_SIZE) begin
				rank_cfg = data[RANK_W-1:0];
				clear_histories();
			end
		endfunction

		function void push_outcome(int s, bit ok);
			int len;
			int pos;
			int cnt;
			len = hist_len();
			pos = wpos[s];
			if (pos >= len) pos = 0;
			hist[s][pos] = ok;
			pos++;
			wpos[s] = (pos >= len) ? 0 : pos;
			if (fill[s] < len) fill[s]++;
			if (fill[s] > len) fill[s] = len;
			cnt = 0;
			for (int i = 0; i < fill[s]; i++) cnt += hist[s][i];
			tally[s] = cnt;
		endfunction

		function void note_word(logic k, logic [SIDX_W-1:0] idx, logic ok);
			pick_t p;
			int n;
			int best;
			bit have;
			n = group_len();
			have = 1'b0;
			best = 0;
			if (k == KIND_REQUEST) begin
				for (int i = 0; i < n; i++) begin
					if (!tried[i] && (!have || tally[i] > tally[best])) begin
						have = 1'b1;
						best = i;
					end
				end
				if (have) begin
					tried[best] = 1'b1;
					p.found = 1'b1;
					p.sensor = SIDX_W'(best);
					p.score = SCORE_W'(tally[best]);
					last_pick = best;
				end else begin
					clear_tried();
					p = '0;
					last_pick = -1;
				end
			end else begin
				if (idx < n) begin
					push_outcome(idx, ok);
					if (ok) clear_tried();
				end
				p.found = 1'b1;
				p.sensor = idx;
				p.score = SCORE_W'(tally[idx]);
			end
			picks_due.push_back(p);
		endfunction

		task report_mismatch(string what);
			$display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		task check_word(logic f, logic [SIDX_W-1:0] s, logic [SCORE_W-1:0] sc);
			pick_t p;
			checked++;
			if (picks_due.size() == 0) begin
				report_mismatch($sformatf("word with none pending: found %0b sensor %0d score %0d",
					f, s, sc));
			end else begin
				p = picks_due.pop_front();
				if (f !== p.found)
					report_mismatch($sformatf("word %0d found %0b, want %0b", checked, f, p.found));
				if (s !== p.sensor)
					report_mismatch($sformatf("word %0d sensor %0d, want %0d", checked, s, p.sensor));
				if (sc !== p.score)
					report_mismatch($sformatf("word %0d score %0d, want %0d", checked, sc, p.score));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [SIDX_W-1:0] sensor_index;
	logic outcome_ok;
	logic out_valid;
	logic out_ready;
	logic found;
	logic [SIDX_W-1:0] chosen_sensor;
	logic [SCORE_W-1:0] score;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	failover_board ranker;
	int words_sent = 0;
	int cfg_writes = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	int stall_mode = STALL_NONE;
	int mode_left = 0;
	logic [7:0] stall_pattern = 8'b1101_0110;
	int phase_group [PHASES] = '{16, 33, 0, 31, 5, 17, 3, 16};
	int phase_rank [PHASES] = '{32, 1, 0, 63, 3, 33, -1, 8};
	int ph;
	int g;
	int r;

	ranked_sensor_failover_selector dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.sensor_index(sensor_index),
		.outcome_ok(outcome_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.chosen_sensor(chosen_sensor),
		.score(score),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sender bursts: valid drops only between bursts
	task pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(5) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 12);
		end
	endtask

	task send_word(logic k, logic [SIDX_W-1:0] idx, logic ok);
		in_valid <= 1'b1;
		kind <= k;
		sensor_index <= idx;
		outcome_ok <= ok;
		do @(posedge clk); while (!in_ready);
		ranker.note_word(k, idx, ok);
		words_sent++;
		pace();
	endtask

	task settle();
		in_valid <= 1'b0;
		while (ranker.picks_due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		ranker.write_reg(idx, data);
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task directed_words();
		send_word(KIND_REQUEST, 4'd0, 1'b0);
		send_word(KIND_REPORT, 4'd15, 1'b1);
		send_word(KIND_REPORT, 4'd15, 1'b0);
		send_word(KIND_REPORT, 4'd9, 1'b1);
		repeat (3) send_word(KIND_REQUEST, 4'd15, 1'b1);
		settle();
		// small group: run out of candidates, then out-of-group report
		write_reg(REG_SENSORS_IN_USE, 6'd2);
		repeat (3) send_word(KIND_REQUEST, 4'd0, 1'b0);
		send_word(KIND_REPORT, 4'd9, 1'b1);
		send_word(KIND_REPORT, 4'd1, 1'b1);
		send_word(KIND_REQUEST, 4'd0, 1'b0);
		settle();
		// empty group
		write_reg(REG_SENSORS_IN_USE, 6'd0);
		send_word(KIND_REQUEST, 4'd5, 1'b1);
		send_word(KIND_REPORT, 4'd3, 1'b1);
		settle();
		// oversized group, one-deep history
		write_reg(REG_SENSORS_IN_USE, 6'd31);
		write_reg(REG_RANK_SIZE, 6'd1);
		send_word(KIND_REPORT, 4'd4, 1'b1);
		send_word(KIND_REPORT, 4'd4, 1'b1);
		send_word(KIND_REPORT, 4'd4, 1'b0);
		send_word(KIND_REQUEST, 4'd0, 1'b0);
		settle();
		// zero history size behaves as one
		write_reg(REG_RANK_SIZE, 6'd0);
		send_word(KIND_REPORT, 4'd4, 1'b1);
		send_word(KIND_REPORT, 4'd4, 1'b0);
		send_word(KIND_REPORT, 4'd4, 1'b1);
		settle();
	endtask

	// mostly failover chains: request, then report on the sensor just chosen
	task random_words(int count);
		int i;
		int pick;
		int n;
		int run;
		int s;
		bit lean;
		i = 0;
		while (i < count) begin
			n = ranker.group_len();
			pick = $urandom_range(99);
			if (pick < 8) begin
				run = $urandom_range(10, 40);
				s = (n > 0) ? $urandom_range(n - 1) : $urandom_range(NSENS - 1);
				lean = 1'($urandom_range(1));
				repeat (run) send_word(KIND_REPORT, SIDX_W'(s),
					($urandom_range(3) == 0) ? !lean : lean);
				i += run;
			end else if (pick < 38) begin
				send_word(KIND_REQUEST, SIDX_W'($urandom), 1'($urandom));
				i++;
			end else if (pick < 75 && ranker.last_pick >= 0) begin
				send_word(KIND_REPORT, SIDX_W'(ranker.last_pick), $urandom_range(2) == 0);
				i++;
			end else if (pick < 92 && n > 0) begin
				send_word(KIND_REPORT, SIDX_W'($urandom_range(n - 1)), 1'($urandom_range(1)));
				i++;
			end else begin
				send_word(KIND_REPORT, SIDX_W'($urandom), 1'($urandom));
				i++;
			end
		end
	endtask

	// receiver: stall patterns plus long hold-offs at two points
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			ranker.check_word(found, chosen_sensor, score);
			if (ranker.checked == 200 || ranker.checked == 900) hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(STALL_PATTERN);
			mode_left = $urandom_range(20, 120);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (stall_mode)
				STALL_NONE: out_ready <= 1'b1;
				STALL_RANDOM: out_ready <= ($urandom_range(2) != 0);
				default: begin
					out_ready <= stall_pattern[0];
					stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("** ranked_sensor_failover_selector: FAILED **");
			$finish;
		end
	end

	initial begin
		ranker = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_REQUEST;
		sensor_index <= '0;
		outcome_ok <= 1'b0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SENSORS_IN_USE;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		for (ph = 0; ph < PHASES; ph++) begin
			g = phase_group[ph];
			r = phase_rank[ph];
			if (ph == 4) begin
				g = $urandom_range(1, NSENS);
				r = $urandom_range(1, NRANK);
				write_reg(REG_SPARE, CFG_DATA_W'($urandom));
			end
			write_reg(REG_SENSORS_IN_USE, CFG_DATA_W'(g));
			if (r >= 0) write_reg(REG_RANK_SIZE, CFG_DATA_W'(r));
			random_words(PHASE_WORDS);
			settle();
		end
		repeat (40) @(posedge clk);
		$display("sent %0d words across %0d register writes, checked %0d results, %0d mismatches",
			words_sent, cfg_writes, ranker.checked, ranker.errors);
		if (ranker.errors == 0 && ranker.picks_due.size() == 0)
			$display("** ranked_sensor_failover_selector: PASSED **");
		else
			$display("** ranked_sensor_failover_selector: FAILED **");
		$finish;
	end
endmodule
